// ===== sv/efv_pkg.sv =====
// ----------------------------------------------------------------------------
// efv_pkg
// Shared types and constants for the EDID fetch validator.
// ----------------------------------------------------------------------------
package efv_pkg;

    localparam int unsigned LANES = 8;

    localparam logic [63:0] HEADER_WORD = 64'h00FF_FFFF_FFFF_FF00;

    localparam logic [5:0] BLOCK0_PACKETS = 6'd16;
    localparam logic [5:0] TOTAL_PACKETS  = 6'd32;
    localparam int unsigned EXT_FLAG_BYTE = 6;

    localparam logic [3:0] DEFER_LIMIT_RESET  = 4'd10;
    localparam logic [5:0] SEARCH_LIMIT_RESET = 6'd32;

    localparam int unsigned ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_DEFER_RETRY_LIMIT   = 1'b0,
        REG_HEADER_SEARCH_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PACKET = 2'd1,
        OP_DEFER  = 2'd2,
        OP_FAIL   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_HEADER  = 2'd1,
        ST_BAD_SUM    = 2'd2,
        ST_XFER_ERROR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SEARCH = 3'd1,
        PH_BLOCK0 = 3'd2,
        PH_EXT    = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] packet_data;
    } efv_req_t;

    typedef struct packed {
        logic        store_valid;
        logic [4:0]  store_index;
        logic [63:0] store_data;
        logic        done_res;
        logic [1:0]  status;
        logic        has_extension;
    } efv_rsp_t;

    typedef struct packed {
        logic [7:0] value;
        logic       match;
    } efv_lane_t;

    typedef struct packed {
        logic [7:0] byte_sum;
        logic       is_header;
    } efv_merge_t;

endpackage

// ===== sv/efv_lane.sv =====
// ----------------------------------------------------------------------------
// efv_lane
// One byte lane: compares its byte against the header byte of its position.
// ----------------------------------------------------------------------------
module efv_lane (
    input  logic [7:0]        data_byte,
    input  logic [7:0]        header_byte,
    output efv_pkg::efv_lane_t lane
);
    import efv_pkg::*;

    always_comb
    begin
        lane.value = data_byte;
        lane.match = (data_byte == header_byte);
    end

endmodule

// ===== sv/efv_merge.sv =====
// ----------------------------------------------------------------------------
// efv_merge
// Merges the byte lanes: an adder tree for the modulo-256 sum and an AND of
// the header matches.
// ----------------------------------------------------------------------------
module efv_merge (
    input  efv_pkg::efv_lane_t lanes [8],
    output efv_pkg::efv_merge_t merged
);
    import efv_pkg::*;

    logic [7:0] level1 [4];
    logic [7:0] level2 [2];
    logic       all_match;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            level1[i] = lanes[2*i].value + lanes[2*i+1].value;
        end
        for (int i = 0; i < 2; i++)
        begin
            level2[i] = level1[2*i] + level1[2*i+1];
        end
        all_match = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            all_match = all_match & lanes[i].match;
        end
        merged.byte_sum  = level2[0] + level2[1];
        merged.is_header = all_match;
    end

endmodule

// ===== sv/edid_fetch_validator.sv =====
// ----------------------------------------------------------------------------
// edid_fetch_validator
// Searches AUX read beats for the EDID header, stores block 0 and an optional
// extension block, and checks each block's checksum.
//
//   Channel  Direction  Handshake          Beat
//   req      in         req_valid/req_stall  opcode, packet_data
//   rsp      out        rsp_valid/rsp_stall  store and completion fields
//   config   in         APB (psel/penable)   defer and search limits
//
// A new request beat may be accepted every cycle while req_stall is low.
// The eight byte lanes and the merge tree finish within the accepting cycle.
// Results pass through an output register backed by one skid entry, so
// req_stall rises only while the skid entry is occupied.
// Reset leaves the block idle with both limits at their default values.
// ----------------------------------------------------------------------------
module edid_fetch_validator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  efv_pkg::efv_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output efv_pkg::efv_rsp_t             rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [efv_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import efv_pkg::*;

    logic [3:0] defer_limit_reg;
    logic [5:0] search_limit_reg;

    phase_t     phase_reg, phase_next;
    logic [5:0] packet_count_reg, packet_count_next;
    logic [3:0] defer_count_reg, defer_count_next;
    logic [7:0] byte_sum_reg, byte_sum_next;
    logic       ext_flag_reg, ext_flag_next;

    efv_rsp_t   out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    efv_rsp_t   skid_reg, skid_next;
    logic       skid_valid_reg, skid_valid_next;

    efv_lane_t  lanes [8];
    efv_merge_t merged;

    efv_rsp_t   result;
    logic       result_valid;
    logic       accept;
    logic       take;
    logic       active;
    logic [3:0] defer_lim;
    logic [3:0] defer_inc;
    logic [5:0] search_lim;
    logic [5:0] packet_inc;
    logic [7:0] sum_next;
    reg_index_t wr_index;

    // Configuration port.
    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defer_limit_reg  <= DEFER_LIMIT_RESET;
            search_limit_reg <= SEARCH_LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (wr_index)
                REG_DEFER_RETRY_LIMIT:   defer_limit_reg  <= pwdata[3:0];
                REG_HEADER_SEARCH_LIMIT: search_limit_reg <= pwdata[5:0];
                default:                 defer_limit_reg  <= defer_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (wr_index)
            REG_DEFER_RETRY_LIMIT:   prdata = {28'd0, defer_limit_reg};
            REG_HEADER_SEARCH_LIMIT: prdata = {26'd0, search_limit_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // Byte lanes and merge tree.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        efv_lane u_lane (
            .data_byte   (req.packet_data[8*g +: 8]),
            .header_byte (HEADER_WORD[8*g +: 8]),
            .lane        (lanes[g])
        );
    end

    efv_merge u_merge (
        .lanes  (lanes),
        .merged (merged)
    );

    // Handshake and output buffering.
    assign accept    = req_valid && !skid_valid_reg;
    assign take      = out_valid_reg && !rsp_stall;
    assign req_stall = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Read sequencer.
    always_comb
    begin
        phase_next        = phase_reg;
        packet_count_next = packet_count_reg;
        defer_count_next  = defer_count_reg;
        byte_sum_next     = byte_sum_reg;
        ext_flag_next     = ext_flag_reg;
        result            = '0;
        result_valid      = 1'b0;

        active     = (phase_reg == PH_SEARCH) || (phase_reg == PH_BLOCK0) ||
                     (phase_reg == PH_EXT);
        defer_lim  = (defer_limit_reg == 4'd0) ? 4'd1 : defer_limit_reg;
        defer_inc  = defer_count_reg + 4'd1;
        search_lim = (search_limit_reg == 6'd0) ? 6'd1 : search_limit_reg;
        packet_inc = packet_count_reg + 6'd1;
        sum_next   = byte_sum_reg + merged.byte_sum;

        if (accept)
        begin
            if (opcode_t'(req.opcode) == OP_START)
            begin
                phase_next        = PH_SEARCH;
                packet_count_next = 6'd0;
                defer_count_next  = 4'd0;
                byte_sum_next     = 8'd0;
                ext_flag_next     = 1'b0;
            end
            else if (active)
            begin
                case (opcode_t'(req.opcode))
                    OP_FAIL:
                    begin
                        phase_next           = PH_DONE;
                        result_valid         = 1'b1;
                        result.done_res      = 1'b1;
                        result.status        = ST_XFER_ERROR;
                        result.has_extension = ext_flag_reg;
                    end
                    OP_DEFER:
                    begin
                        defer_count_next = defer_inc;
                        if (defer_inc == 4'd0 || defer_inc >= defer_lim)
                        begin
                            phase_next           = PH_DONE;
                            result_valid         = 1'b1;
                            result.done_res      = 1'b1;
                            result.status        = ST_XFER_ERROR;
                            result.has_extension = ext_flag_reg;
                        end
                    end
                    OP_PACKET:
                    begin
                        defer_count_next = 4'd0;
                        if (phase_reg == PH_SEARCH)
                        begin
                            packet_count_next = packet_inc;
                            if (merged.is_header)
                            begin
                                phase_next         = PH_BLOCK0;
                                packet_count_next  = 6'd1;
                                byte_sum_next      = merged.byte_sum;
                                result_valid       = 1'b1;
                                result.store_valid = 1'b1;
                                result.store_index = 5'd0;
                                result.store_data  = req.packet_data;
                            end
                            else if (packet_inc == 6'd0 || packet_inc >= search_lim)
                            begin
                                phase_next           = PH_DONE;
                                result_valid         = 1'b1;
                                result.done_res      = 1'b1;
                                result.status        = ST_NO_HEADER;
                                result.has_extension = ext_flag_reg;
                            end
                        end
                        else
                        begin
                            packet_count_next  = packet_inc;
                            byte_sum_next      = sum_next;
                            result_valid       = 1'b1;
                            result.store_valid = 1'b1;
                            result.store_index = packet_count_reg[4:0];
                            result.store_data  = req.packet_data;
                            if (phase_reg == PH_BLOCK0)
                            begin
                                if (packet_inc >= BLOCK0_PACKETS)
                                begin
                                    if (sum_next != 8'd0)
                                    begin
                                        phase_next           = PH_DONE;
                                        result.done_res      = 1'b1;
                                        result.status        = ST_BAD_SUM;
                                        result.has_extension = ext_flag_reg;
                                    end
                                    else if (req.packet_data[8*EXT_FLAG_BYTE +: 8] != 8'd0)
                                    begin
                                        phase_next    = PH_EXT;
                                        ext_flag_next = 1'b1;
                                        byte_sum_next = 8'd0;
                                    end
                                    else
                                    begin
                                        phase_next           = PH_DONE;
                                        result.done_res      = 1'b1;
                                        result.status        = ST_OK;
                                        result.has_extension = ext_flag_reg;
                                    end
                                end
                            end
                            else if (packet_inc >= TOTAL_PACKETS)
                            begin
                                phase_next           = PH_DONE;
                                result.done_res      = 1'b1;
                                result.status        = (sum_next != 8'd0) ? ST_BAD_SUM
                                                                          : ST_OK;
                                result.has_extension = ext_flag_reg;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Output register and skid entry.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = result;
                out_valid_next = result_valid;
            end
        end
        else if (!out_valid_reg)
        begin
            out_next       = result;
            out_valid_next = result_valid;
        end
        else if (result_valid)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            packet_count_reg <= 6'd0;
            defer_count_reg  <= 4'd0;
            byte_sum_reg     <= 8'd0;
            ext_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            packet_count_reg <= packet_count_next;
            defer_count_reg  <= defer_count_next;
            byte_sum_reg     <= byte_sum_next;
            ext_flag_reg     <= ext_flag_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== test/edid_fetch_validator_tb.sv =====
// ----------------------------------------------------------------------------
// edid_fetch_validator_tb
// Self-checking testbench for the EDID fetch validator. Request beats are
// driven through the valid/stall channel and tracked by a cycle-free model
// of the header search, block checksums and retry handling; every response
// beat is compared field by field against the oldest predicted beat.
// Both limits are programmed over APB across several settings, with random
// idling on both channels, a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module edid_fetch_validator_tb;
    import efv_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int FLUSH_LIMIT  = 20000;
    localparam int PHASE_BEATS  = 140;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    efv_req_t            req;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    efv_rsp_t            rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    efv_rsp_t            pending_rsp[$];
    logic [63:0]         blk[16];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  beats_used  = 0;
    int                  hold_left   = 0;
    bit                  steady      = 1'b0;

    phase_t              ph;
    logic [5:0]          pkt_cnt;
    logic [3:0]          dfr_cnt;
    logic [7:0]          sum8;
    logic                ext_flag;
    logic [3:0]          cfg_defer;
    logic [5:0]          cfg_search;

    edid_fetch_validator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("edid_fetch_validator test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            rsp_stall <= !steady && ($urandom_range(99) < 25);
        end
    end

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] byte_total(input logic [63:0] d);
        logic [7:0] s;
        s = '0;
        for (int b = 0; b < LANES; b++)
        begin
            s += d[8*b +: 8];
        end
        return s;
    endfunction

    function automatic void reset_edid_model();
        ph         = PH_IDLE;
        pkt_cnt    = '0;
        dfr_cnt    = '0;
        sum8       = '0;
        ext_flag   = 1'b0;
        cfg_defer  = DEFER_LIMIT_RESET;
        cfg_search = SEARCH_LIMIT_RESET;
    endfunction

    // Advances the model by one request beat and queues the response it causes.
    // Returns zero when the beat is ignored by the block.
    function automatic bit track_edid(input opcode_t op, input logic [63:0] d);
        efv_rsp_t   r;
        logic [3:0] dlim;
        logic [5:0] slim;
        bit         emit;
        bit         fin;
        bit         used;
        r    = '0;
        emit = 1'b0;
        fin  = 1'b0;
        used = (op == OP_START) || (ph == PH_SEARCH) || (ph == PH_BLOCK0) || (ph == PH_EXT);
        if (op == OP_START)
        begin
            ph       = PH_SEARCH;
            pkt_cnt  = '0;
            dfr_cnt  = '0;
            sum8     = '0;
            ext_flag = 1'b0;
        end
        else if (used)
        begin
            if (op == OP_FAIL)
            begin
                fin      = 1'b1;
                r.status = ST_XFER_ERROR;
            end
            else if (op == OP_DEFER)
            begin
                dlim    = (cfg_defer == 4'd0) ? 4'd1 : cfg_defer;
                dfr_cnt = dfr_cnt + 4'd1;
                if (dfr_cnt == 4'd0 || dfr_cnt >= dlim)
                begin
                    fin      = 1'b1;
                    r.status = ST_XFER_ERROR;
                end
            end
            else if (ph == PH_SEARCH)
            begin
                dfr_cnt = '0;
                slim    = (cfg_search == 6'd0) ? 6'd1 : cfg_search;
                pkt_cnt = pkt_cnt + 6'd1;
                if (d == HEADER_WORD)
                begin
                    ph           = PH_BLOCK0;
                    pkt_cnt      = 6'd1;
                    sum8         = byte_total(d);
                    emit         = 1'b1;
                    r.store_valid = 1'b1;
                    r.store_data  = d;
                end
                else if (pkt_cnt == 6'd0 || pkt_cnt >= slim)
                begin
                    fin      = 1'b1;
                    r.status = ST_NO_HEADER;
                end
            end
            else
            begin
                dfr_cnt       = '0;
                r.store_valid = 1'b1;
                r.store_index = pkt_cnt[4:0];
                r.store_data  = d;
                emit          = 1'b1;
                sum8          = sum8 + byte_total(d);
                pkt_cnt       = pkt_cnt + 6'd1;
                if (ph == PH_BLOCK0)
                begin
                    if (pkt_cnt == BLOCK0_PACKETS)
                    begin
                        if (sum8 != 8'd0)
                        begin
                            fin      = 1'b1;
                            r.status = ST_BAD_SUM;
                        end
                        else if (d[8*EXT_FLAG_BYTE +: 8] != 8'd0)
                        begin
                            ext_flag = 1'b1;
                            ph       = PH_EXT;
                            sum8     = '0;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                end
                else if (pkt_cnt == TOTAL_PACKETS)
                begin
                    fin      = 1'b1;
                    r.status = (sum8 != 8'd0) ? ST_BAD_SUM : ST_OK;
                end
            end
        end
        if (fin)
        begin
            ph              = PH_DONE;
            r.done_res      = 1'b1;
            r.has_extension = ext_flag;
            emit            = 1'b1;
        end
        if (emit)
        begin
            pending_rsp.push_back(r);
        end
        return used;
    endfunction

    always @(posedge clk)
    begin
        efv_rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_error($sformatf(
                    "unexpected response beat sv=%0b idx=%0d data=%h done=%0b st=%0d ext=%0b",
                    rsp.store_valid, rsp.store_index, rsp.store_data, rsp.done_res,
                    rsp.status, rsp.has_extension));
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (e.store_valid !== rsp.store_valid || e.store_index !== rsp.store_index ||
                    e.store_data !== rsp.store_data || e.done_res !== rsp.done_res ||
                    e.status !== rsp.status || e.has_extension !== rsp.has_extension)
                begin
                    report_error({
                        $sformatf("expected sv=%0b idx=%0d data=%h done=%0b st=%0d ext=%0b",
                            e.store_valid, e.store_index, e.store_data, e.done_res,
                            e.status, e.has_extension),
                        $sformatf(", got sv=%0b idx=%0d data=%h done=%0b st=%0d ext=%0b",
                            rsp.store_valid, rsp.store_index, rsp.store_data,
                            rsp.done_res, rsp.status, rsp.has_extension)});
                end
            end
        end
    end

    task automatic send_beat(input opcode_t op, input logic [63:0] d);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 25)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid       <= 1'b1;
        req.opcode      <= op;
        req.packet_data <= d;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        if (track_edid(op, d))
        begin
            beats_used++;
        end
    endtask

    task automatic idle_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_DEFER_RETRY_LIMIT)
        begin
            cfg_defer = value[3:0];
        end
        else
        begin
            cfg_search = value[5:0];
        end
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((idx == REG_DEFER_RETRY_LIMIT && rd[3:0] !== cfg_defer) ||
            (idx == REG_HEADER_SEARCH_LIMIT && rd[5:0] !== cfg_search))
        begin
            report_error($sformatf("register %0d read back %h after writing %h",
                idx, rd, value));
        end
    endtask

    // Fills blk with one 128-byte block; byte 127 balances the checksum unless
    // a bad sum is wanted, and byte 126 flags the extension.
    function automatic void fill_block(input bit base, input bit ext, input bit good);
        logic [7:0] s;
        s = '0;
        for (int i = 0; i < 16; i++)
        begin
            blk[i] = rand64();
        end
        if (base)
        begin
            blk[0] = HEADER_WORD;
        end
        blk[15][8*EXT_FLAG_BYTE +: 8] = ext ? 8'($urandom_range(255, 1)) : 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (!(i == 15 && b == 7))
                begin
                    s += blk[i][8*b +: 8];
                end
            end
        end
        blk[15][63:56] = (8'd0 - s) + (good ? 8'd0 : 8'($urandom_range(255, 1)));
    endfunction

    task automatic send_packet(input logic [63:0] d, input int defer_pct);
        int lim;
        lim = (cfg_defer > 4'd1) ? int'(cfg_defer) - 1 : 1;
        if ($urandom_range(19) == 0)
        begin
            lim = int'(cfg_defer) + 1;
        end
        if ($urandom_range(99) < defer_pct)
        begin
            repeat ($urandom_range(lim, 1)) send_beat(OP_DEFER, rand64());
        end
        send_beat(OP_PACKET, d);
    endtask

    task automatic send_read(input int defer_pct);
        int          slim;
        int          pre;
        int          cut;
        int          i;
        bit          want_ext;
        bit          good0;
        bit          good1;
        logic [63:0] w;
        slim     = (cfg_search == 6'd0) ? 1 : int'(cfg_search);
        pre      = ($urandom_range(9) == 0) ? $urandom_range(slim + 1, 0)
                                            : $urandom_range((slim > 4) ? 3 : slim - 1, 0);
        cut      = ($urandom_range(7) == 0) ? $urandom_range(31, 0) : 99;
        want_ext = 1'($urandom_range(1));
        good0    = ($urandom_range(9) != 0);
        good1    = ($urandom_range(9) != 0);
        send_beat(OP_START, rand64());
        repeat (pre)
        begin
            w = rand64();
            if (w == HEADER_WORD)
            begin
                w[0] = 1'b1;
            end
            send_packet(w, defer_pct);
        end
        fill_block(1'b1, want_ext, good0);
        for (i = 0; i < 32; i++)
        begin
            if (i == cut)
            begin
                send_beat($urandom_range(1) ? OP_FAIL : OP_START, rand64());
                return;
            end
            if (i == 16)
            begin
                if (!(want_ext && good0))
                begin
                    return;
                end
                fill_block(1'b0, 1'($urandom_range(1)), good1);
            end
            send_packet(blk[i % 16], defer_pct);
        end
    endtask

    task automatic test_directed_cases();
        send_beat(OP_PACKET, HEADER_WORD);
        send_beat(OP_DEFER, '0);
        send_beat(OP_FAIL, '1);
        idle_until_drained();
        write_reg(REG_DEFER_RETRY_LIMIT, 2);
        write_reg(REG_HEADER_SEARCH_LIMIT, 2);
        send_beat(OP_START, '1);
        send_beat(OP_PACKET, '0);
        send_beat(OP_PACKET, '1);
        send_beat(OP_PACKET, HEADER_WORD);
        send_beat(OP_START, '0);
        send_beat(OP_DEFER, '1);
        send_beat(OP_DEFER, '0);
        send_beat(OP_START, '0);
        send_beat(OP_DEFER, '0);
        send_beat(OP_PACKET, HEADER_WORD);
        send_beat(OP_DEFER, '0);
        send_beat(OP_PACKET, '1);
        send_beat(OP_FAIL, '0);
        send_beat(OP_START, '0);
        send_beat(OP_PACKET, HEADER_WORD);
        send_beat(OP_START, '1);
        send_beat(OP_PACKET, HEADER_WORD);
        send_beat(OP_FAIL, '1);
    endtask

    // The receiver stops long enough for the output register and skid entry
    // to fill, so the block must stall its request side.
    task automatic test_receiver_holdoff();
        int i;
        idle_until_drained();
        write_reg(REG_DEFER_RETRY_LIMIT, 32'(DEFER_LIMIT_RESET));
        write_reg(REG_HEADER_SEARCH_LIMIT, 32'(SEARCH_LIMIT_RESET));
        hold_left = 300;
        send_beat(OP_START, rand64());
        fill_block(1'b1, 1'b1, 1'b1);
        for (i = 0; i < 16; i++)
        begin
            send_beat(OP_PACKET, blk[i]);
        end
        fill_block(1'b0, 1'b1, 1'b1);
        for (i = 0; i < 16; i++)
        begin
            send_beat(OP_PACKET, blk[i]);
        end
    endtask

    task automatic test_sender_pause();
        int i;
        send_beat(OP_START, rand64());
        fill_block(1'b1, 1'b0, 1'b1);
        for (i = 0; i < 16; i++)
        begin
            if (i == 6)
            begin
                idle_until_drained();
            end
            send_beat(OP_PACKET, blk[i]);
        end
    endtask

    task automatic test_config_sweep();
        int defer_set[6]  = '{10, 1, 15, 0, 3, 0};
        int search_set[6] = '{32, 1, 63, 0, 5, 0};
        int p;
        int goal;
        for (p = 0; p < 6; p++)
        begin
            idle_until_drained();
            steady = (p == 2);
            if (p == 5)
            begin
                defer_set[p]  = $urandom_range(15, 1);
                search_set[p] = $urandom_range(63, 1);
            end
            write_reg(REG_DEFER_RETRY_LIMIT, defer_set[p]);
            write_reg(REG_HEADER_SEARCH_LIMIT, search_set[p]);
            goal = beats_used + PHASE_BEATS;
            while (beats_used < goal)
            begin
                if ($urandom_range(99) < 85)
                begin
                    send_read(8);
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                        send_beat(opcode_t'($urandom_range(3)), rand64());
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        reset_edid_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_receiver_holdoff();
        test_sender_pause();
        test_config_sweep();

        @(negedge clk);
        req_valid <= 1'b0;
        for (i = 0; i < FLUSH_LIMIT && pending_rsp.size() != 0; i++)
        begin
            @(posedge clk);
        end
        if (pending_rsp.size() != 0)
        begin
            report_error($sformatf("%0d response beats never arrived", pending_rsp.size()));
        end
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("edid_fetch_validator test passed");
        end
        else
        begin
            $display("edid_fetch_validator test failed");
        end
        $finish;
    end

endmodule
